// ===== src/assert_macros.svh =====
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property that must hold at every clock edge out of reset
`define SSD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define SSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define SSD_ASSERT(lbl, clk, rst_n, prop)
`define SSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/ssd_pkg.sv =====
`default_nettype none

package ssd_pkg;

  // bits shifted per frame, word bits beyond the segment word go out as zero
  localparam int FRAME_BITS = 16;
  localparam int BIT_CW     = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;

  localparam int WORD_W = 16;

  // depth of the job queue between front and back
  localparam int JOB_DEPTH = 2;
  localparam int JOB_PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
  localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

  // reciprocal of ten, exact for 16-bit dividends after a shift by 19
  localparam logic [15:0] RECIP_TEN = 16'hCCCD;
  localparam int          RECIP_SH  = 19;

  localparam logic [WORD_W-1:0] HI_MASK = 16'hFF00;
  localparam logic [WORD_W-1:0] LO_MASK = 16'h00FF;

  typedef enum logic [2:0] {
    ACT_REFRESH = 3'd0,
    ACT_NUMBER  = 3'd1,
    ACT_DIGIT   = 3'd2,
    ACT_RAW     = 3'd3,
    ACT_MATRIX  = 3'd4
  } act_e;

  typedef struct packed {
    logic [2:0]        action;
    logic [WORD_W-1:0] value;
    logic              pos;
  } cmd_t;

  typedef struct packed {
    logic disp_reset_n;
    logic serial_data;
    logic serial_clock;
    logic disp_latch;
    logic matrix_col_clock;
    logic matrix_reset_n;
    logic matrix_latch;
    logic last;
  } pin_t;

  // one queued waveform: which display and the word to shift
  typedef struct packed {
    logic              is_matrix;
    logic [WORD_W-1:0] word;
  } job_t;

  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    case (digit)
      4'd0:    code = 8'h7E;
      4'd1:    code = 8'h50;
      4'd2:    code = 8'h6D;
      4'd3:    code = 8'h79;
      4'd4:    code = 8'h53;
      4'd5:    code = 8'h3B;
      4'd6:    code = 8'h3F;
      4'd7:    code = 8'h70;
      4'd8:    code = 8'h7F;
      4'd9:    code = 8'h7B;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== src/ssd_front.sv =====
`default_nettype none

module ssd_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push,
  output logic              full,
  input  wire ssd_pkg::cmd_t cmd_i,
  output logic              job_push_o,
  output ssd_pkg::job_t     job_o,
  input  wire logic         job_full_i
);

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_DIV,
    FE_PUSH
  } fe_state_e;

  fe_state_e                     state_q;
  ssd_pkg::cmd_t                 cmd_q;
  logic [ssd_pkg::WORD_W-1:0]    seg_word_q, seg_word_d;
  logic [12:0]                   quot_q, quot_d;
  logic [3:0]                    ones_q, ones_d;

  logic [ssd_pkg::WORD_W-1:0]    dividend;
  logic [31:0]                   prod1;
  logic [15:0]                   rem1;
  logic [28:0]                   prod2;
  logic [9:0]                    quot2;
  logic [12:0]                   rem2;
  logic [3:0]                    tens;
  logic [7:0]                    byte_new;
  logic                          act_ok;

  // first divide by ten: ones digit and quotient
  always_comb begin
    if (cmd_q.action == ssd_pkg::ACT_DIGIT) begin
      dividend = {8'd0, cmd_q.value[7:0]};
    end else begin
      dividend = cmd_q.value;
    end
    prod1  = {16'd0, dividend} * {16'd0, ssd_pkg::RECIP_TEN};
    quot_d = prod1[ssd_pkg::RECIP_SH +: 13];
    rem1   = dividend - {quot_d, 3'd0} - {2'd0, quot_d, 1'd0};
    ones_d = rem1[3:0];
  end

  // second divide by ten on the registered quotient, then the word update
  always_comb begin
    prod2  = {16'd0, quot_q} * {13'd0, ssd_pkg::RECIP_TEN};
    quot2  = prod2[ssd_pkg::RECIP_SH +: 10];
    rem2   = quot_q - {quot2, 3'd0} - {2'd0, quot2, 1'd0};
    tens   = rem2[3:0];
    act_ok = cmd_q.action inside {ssd_pkg::ACT_REFRESH, ssd_pkg::ACT_NUMBER,
                                  ssd_pkg::ACT_DIGIT, ssd_pkg::ACT_RAW,
                                  ssd_pkg::ACT_MATRIX};

    if (cmd_q.action == ssd_pkg::ACT_DIGIT) begin
      byte_new = ssd_pkg::seg_code(ones_q);
    end else begin
      byte_new = cmd_q.value[7:0];
    end

    seg_word_d = seg_word_q;
    case (cmd_q.action)
      ssd_pkg::ACT_NUMBER: begin
        seg_word_d = {ssd_pkg::seg_code(tens), ssd_pkg::seg_code(ones_q)};
      end
      ssd_pkg::ACT_DIGIT, ssd_pkg::ACT_RAW: begin
        if (cmd_q.pos) begin
          seg_word_d = (seg_word_q & ssd_pkg::LO_MASK) | {byte_new, 8'd0};
        end else begin
          seg_word_d = (seg_word_q & ssd_pkg::HI_MASK) | {8'd0, byte_new};
        end
      end
      default: begin
        seg_word_d = seg_word_q;
      end
    endcase

    job_o.is_matrix = (cmd_q.action == ssd_pkg::ACT_MATRIX);
    job_o.word      = job_o.is_matrix ? cmd_q.value : seg_word_d;
    job_push_o      = (state_q == FE_PUSH) && act_ok && !job_full_i;
  end

  assign full = (state_q != FE_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= FE_IDLE;
      seg_word_q <= '0;
      cmd_q      <= '0;
      quot_q     <= '0;
      ones_q     <= '0;
    end else begin
      case (state_q)
        FE_IDLE: begin
          if (push) begin
            cmd_q   <= cmd_i;
            state_q <= FE_DIV;
          end
        end
        FE_DIV: begin
          quot_q  <= quot_d;
          ones_q  <= ones_d;
          state_q <= FE_PUSH;
        end
        FE_PUSH: begin
          // unknown actions are dropped with no word
          if (!act_ok) begin
            state_q <= FE_IDLE;
          end else if (!job_full_i) begin
            seg_word_q <= seg_word_d;
            state_q    <= FE_IDLE;
          end
        end
        default: begin
          state_q <= FE_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/ssd_job_fifo.sv =====
`default_nettype none

module ssd_job_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire ssd_pkg::job_t  job_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output ssd_pkg::job_t      job_o,
  output logic               empty_o
);

  ssd_pkg::job_t                   mem_q [ssd_pkg::JOB_DEPTH];
  logic [ssd_pkg::JOB_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [ssd_pkg::JOB_CNT_W-1:0]   count_q;
  logic                            do_push, do_pop;

  assign full_o  = (count_q == ssd_pkg::JOB_CNT_W'(ssd_pkg::JOB_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_ptr_q];

  function automatic logic [ssd_pkg::JOB_PTR_W-1:0] ptr_inc(
    input logic [ssd_pkg::JOB_PTR_W-1:0] ptr
  );
    logic [ssd_pkg::JOB_PTR_W-1:0] nxt;
    if (ptr == ssd_pkg::JOB_PTR_W'(ssd_pkg::JOB_DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = ptr + 1'b1;
    end
    return nxt;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/ssd_back.sv =====
`default_nettype none
`include "assert_macros.svh"

module ssd_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ssd_pkg::job_t  job_i,
  input  wire logic          job_empty_i,
  output logic               job_pop_o,
  output logic               empty,
  input  wire logic          pop,
  output ssd_pkg::pin_t      res_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COL_LO,
    ST_COL_HI,
    ST_RST_LO,
    ST_RST_HI,
    ST_BIT_DATA,
    ST_BIT_HI,
    ST_BIT_LO,
    ST_LAT_HI,
    ST_LAT_LO
  } seq_state_e;

  seq_state_e                   state_q, state_d, step;
  ssd_pkg::pin_t                pins_q, pins_d;
  logic                         out_valid_q;
  logic                         mode_q, mode;
  logic [ssd_pkg::WORD_W-1:0]   shift_q;
  logic [ssd_pkg::BIT_CW-1:0]   bit_cnt_q;
  logic                         adv, go, start, last_bit;

  assign adv       = !out_valid_q || pop;
  assign start     = (state_q == ST_IDLE) && !job_empty_i;
  assign go        = adv && ((state_q != ST_IDLE) || !job_empty_i);
  assign job_pop_o = adv && start;
  assign last_bit  = (bit_cnt_q == ssd_pkg::BIT_CW'(ssd_pkg::FRAME_BITS - 1));
  assign empty     = !out_valid_q;
  assign res_o     = pins_q;

  always_comb begin
    if (state_q == ST_IDLE) begin
      mode = job_i.is_matrix;
      step = job_i.is_matrix ? ST_COL_LO : ST_RST_LO;
    end else begin
      mode = mode_q;
      step = state_q;
    end

    pins_d      = pins_q;
    pins_d.last = 1'b0;
    state_d     = state_q;
    case (step)
      ST_COL_LO: begin
        pins_d.matrix_col_clock = 1'b0;
        state_d = ST_COL_HI;
      end
      ST_COL_HI: begin
        pins_d.matrix_col_clock = 1'b1;
        state_d = ST_RST_LO;
      end
      ST_RST_LO: begin
        if (mode) begin
          pins_d.matrix_reset_n = 1'b0;
        end else begin
          pins_d.disp_reset_n = 1'b0;
        end
        state_d = ST_RST_HI;
      end
      ST_RST_HI: begin
        if (mode) begin
          pins_d.matrix_reset_n = 1'b1;
        end else begin
          pins_d.disp_reset_n = 1'b1;
        end
        state_d = ST_BIT_DATA;
      end
      ST_BIT_DATA: begin
        pins_d.serial_data = mode ? shift_q[ssd_pkg::WORD_W-1] : shift_q[0];
        state_d = ST_BIT_HI;
      end
      ST_BIT_HI: begin
        pins_d.serial_clock = 1'b1;
        state_d = ST_BIT_LO;
      end
      ST_BIT_LO: begin
        pins_d.serial_clock = 1'b0;
        state_d = last_bit ? ST_LAT_HI : ST_BIT_DATA;
      end
      ST_LAT_HI: begin
        if (mode) begin
          pins_d.matrix_latch = 1'b1;
        end else begin
          pins_d.disp_latch = 1'b1;
        end
        state_d = ST_LAT_LO;
      end
      ST_LAT_LO: begin
        if (mode) begin
          pins_d.matrix_latch = 1'b0;
        end else begin
          pins_d.disp_latch = 1'b0;
        end
        pins_d.last = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      mode_q      <= 1'b0;
      shift_q     <= '0;
      bit_cnt_q   <= '0;
      pins_q      <= '{disp_reset_n: 1'b1, matrix_col_clock: 1'b1,
                       matrix_reset_n: 1'b1, default: 1'b0};
    end else begin
      if (go) begin
        pins_q      <= pins_d;
        state_q     <= state_d;
        out_valid_q <= 1'b1;
        if (start) begin
          mode_q    <= job_i.is_matrix;
          shift_q   <= job_i.word;
          bit_cnt_q <= '0;
        end
        if (step == ST_BIT_DATA) begin
          // zeros fill in behind the word for long frames
          if (mode) begin
            shift_q <= {shift_q[ssd_pkg::WORD_W-2:0], 1'b0};
          end else begin
            shift_q <= {1'b0, shift_q[ssd_pkg::WORD_W-1:1]};
          end
        end
        if ((step == ST_BIT_LO) && !last_bit) begin
          bit_cnt_q <= bit_cnt_q + 1'b1;
        end
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  `SSD_ASSERT(a_idle_pins, clk_i, rst_ni, (state_q != ST_IDLE) ||
              (pins_q.disp_reset_n && pins_q.matrix_reset_n && pins_q.matrix_col_clock &&
               !pins_q.serial_clock && !pins_q.disp_latch && !pins_q.matrix_latch))
  `SSD_ASSERT(a_last_end, clk_i, rst_ni, !(out_valid_q && pins_q.last) || (state_q == ST_IDLE))
  `SSD_ASSERT_NEXT(a_stall, clk_i, rst_ni, out_valid_q && !pop,
                   out_valid_q && $stable(state_q) && $stable(pins_q))
  `SSD_ASSERT(a_pop_ok, clk_i, rst_ni, !job_pop_o || !job_empty_i)

endmodule

`default_nettype wire

// ===== src/seven_segment_shift_out_driver_core.sv =====
// Serial shift-out driver for a two-digit seven-segment display and a matrix
// row register sharing one data line and one clock line. Commands enter
// through a queue-style port (push/full) and each one yields a pin waveform,
// one word per pin write, read out through a queue-style port (empty/pop);
// the final word of a command has last set. A display command gives
// 3*FRAME_BITS+4 words (52 at the default frame of 16 bits) and a matrix
// command 3*FRAME_BITS+6 (54), and the waveform sequencer issues one word per
// clock when the output is being drained, so the sequencer sets the sustained
// rate. The front end takes a command, does the first divide by ten in its
// divide state and the second with the digit update in its push state, and
// a two-entry job queue lets it run ahead of the sequencer. Actions 5 to 7
// are dropped without any word.
`default_nettype none

module seven_segment_shift_out_driver_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  output logic               full,
  input  wire ssd_pkg::cmd_t  cmd_i,
  output logic               empty,
  input  wire logic          pop,
  output ssd_pkg::pin_t      res_o
);

  // front end to job queue
  logic          job_push;
  ssd_pkg::job_t job_in;
  logic          job_full;

  // job queue to sequencer
  logic          job_pop;
  ssd_pkg::job_t job_out;
  logic          job_empty;

  // decodes commands, keeps the segment word and hands out jobs
  ssd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .cmd_i      (cmd_i),
    .job_push_o (job_push),
    .job_o      (job_in),
    .job_full_i (job_full)
  );

  // short queue so the front and the sequencer stall independently
  ssd_job_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .job_o   (job_out),
    .empty_o (job_empty)
  );

  // pin waveform sequencer, holds the pin levels between commands
  ssd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_out),
    .job_empty_i (job_empty),
    .job_pop_o   (job_pop),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

// ===== tb/tb_seven_segment_shift_out_driver_core.sv =====
`timescale 1ns / 100ps

module tb_seven_segment_shift_out_driver_core;

  // pin indexes inside the model's pin level vector
  localparam logic [2:0] PIN_DRST = 3'd0;
  localparam logic [2:0] PIN_SDI  = 3'd1;
  localparam logic [2:0] PIN_SCK  = 3'd2;
  localparam logic [2:0] PIN_DLAT = 3'd3;
  localparam logic [2:0] PIN_CCLK = 3'd4;
  localparam logic [2:0] PIN_MRST = 3'd5;
  localparam logic [2:0] PIN_MLAT = 3'd6;

  // spare action codes, the block must drop these silently
  localparam logic [2:0] ACT_SPARE_5 = 3'd5;
  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;

  localparam int CMD_W       = $bits(ssd_pkg::cmd_t);
  localparam int RANDOM_CMDS = 135;
  localparam int CYCLE_LIMIT = 1000000;
  // front end steps plus one full matrix waveform, with margin
  localparam int TAIL_CYCLES = 150;

  logic          clk_i  = 1'b0;
  logic          rst_ni = 1'b0;
  logic          push   = 1'b0;
  logic          full;
  ssd_pkg::cmd_t cmd_i  = '0;
  logic          empty;
  logic          pop    = 1'b0;
  ssd_pkg::pin_t res_o;

  seven_segment_shift_out_driver_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .cmd_i  (cmd_i),
    .empty  (empty),
    .pop    (pop),
    .res_o  (res_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // model of the block: segment word and current pin levels
  // ---------------------------------------------------------------------------

  logic [ssd_pkg::WORD_W-1:0] seg_word_m = '0;
  // resets and column clock idle high, everything else low
  logic [6:0]                 pin_lvl    = 7'h31;

  ssd_pkg::pin_t pin_events_q[$];   // pin words still to come out of the block
  ssd_pkg::cmd_t cmd_backlog_q[$];  // commands not yet offered to the block

  int          errors = 0;
  int unsigned cycles = 0;

  // segment pattern of one decimal digit
  function automatic logic [7:0] digit_pattern(input int d);
    logic [7:0] p;
    case (d)
      0:       p = 8'h7E;
      1:       p = 8'h50;
      2:       p = 8'h6D;
      3:       p = 8'h79;
      4:       p = 8'h53;
      5:       p = 8'h3B;
      6:       p = 8'h3F;
      7:       p = 8'h70;
      8:       p = 8'h7F;
      default: p = 8'h7B;
    endcase
    return p;
  endfunction

  // one pin write, every write yields one expected word
  task automatic write_pin(input logic [2:0] idx, input logic lvl);
    ssd_pkg::pin_t ev;
    pin_lvl[idx]        = lvl;
    ev.disp_reset_n     = pin_lvl[PIN_DRST];
    ev.serial_data      = pin_lvl[PIN_SDI];
    ev.serial_clock     = pin_lvl[PIN_SCK];
    ev.disp_latch       = pin_lvl[PIN_DLAT];
    ev.matrix_col_clock = pin_lvl[PIN_CCLK];
    ev.matrix_reset_n   = pin_lvl[PIN_MRST];
    ev.matrix_latch     = pin_lvl[PIN_MLAT];
    ev.last             = 1'b0;
    pin_events_q.push_back(ev);
  endtask

  // data level, clock high, clock low
  task automatic shift_bit(input logic b);
    write_pin(PIN_SDI, b);
    write_pin(PIN_SCK, 1'b1);
    write_pin(PIN_SCK, 1'b0);
  endtask

  // update the segment word and queue the whole pin waveform of one command
  task automatic predict_waveform(input ssd_pkg::cmd_t c);
    logic [7:0]                 byte_v;
    logic                       is_disp;
    logic [ssd_pkg::WORD_W-1:0] sh;
    ssd_pkg::pin_t              tail;
    int                         i;
    is_disp = 1'b1;
    byte_v  = c.value[7:0];
    case (c.action)
      ssd_pkg::ACT_REFRESH: begin
      end
      ssd_pkg::ACT_NUMBER: begin
        // tens to the high digit, ones to the low digit
        seg_word_m = {digit_pattern(int'(c.value) / 10 % 10),
                      digit_pattern(int'(c.value) % 10)};
      end
      ssd_pkg::ACT_DIGIT, ssd_pkg::ACT_RAW: begin
        if (c.action == ssd_pkg::ACT_DIGIT) byte_v = digit_pattern(int'(c.value[7:0]) % 10);
        if (c.pos == 1'b0) seg_word_m = (seg_word_m & ssd_pkg::HI_MASK) | {8'h00, byte_v};
        else seg_word_m = (seg_word_m & ssd_pkg::LO_MASK) | {byte_v, 8'h00};
      end
      ssd_pkg::ACT_MATRIX: begin
        is_disp = 1'b0;
      end
      default: return;  // spare actions give no words at all
    endcase

    if (is_disp) begin
      // display: reset pulse, word lsb first, latch pulse
      write_pin(PIN_DRST, 1'b0);
      write_pin(PIN_DRST, 1'b1);
      sh = seg_word_m;
      for (i = 0; i < ssd_pkg::FRAME_BITS; i++) begin
        // bits past the word come out as zero
        shift_bit(sh[0]);
        sh = sh >> 1;
      end
      write_pin(PIN_DLAT, 1'b1);
      write_pin(PIN_DLAT, 1'b0);
    end else begin
      // matrix: column clock pulse, reset pulse, word msb first, latch pulse
      write_pin(PIN_CCLK, 1'b0);
      write_pin(PIN_CCLK, 1'b1);
      write_pin(PIN_MRST, 1'b0);
      write_pin(PIN_MRST, 1'b1);
      sh = c.value;
      for (i = 0; i < ssd_pkg::FRAME_BITS; i++) begin
        shift_bit(sh[ssd_pkg::WORD_W-1]);
        sh = sh << 1;
      end
      write_pin(PIN_MLAT, 1'b1);
      write_pin(PIN_MLAT, 1'b0);
    end

    // mark the final word of the command
    tail      = pin_events_q[pin_events_q.size()-1];
    tail.last = 1'b1;
    pin_events_q[pin_events_q.size()-1] = tail;
  endtask

  function automatic void compare_level(input string name, input logic expv,
                                        input logic actv);
    if (actv !== expv) begin
      $display("%0t: %s expected %b actual %b", $time, name, expv, actv);
      errors++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // command driver: bursts of random length, random gaps in between
  // ---------------------------------------------------------------------------

  ssd_pkg::cmd_t cur_cmd;
  logic cmd_live   = 1'b0;  // a command is on the port
  logic cmd_taken  = 1'b0;  // set by the monitor when the port accepted it
  int   burst_left = 0;
  int   gap_left   = 0;

  always @(negedge clk_i) begin : drive_cmds
    logic [CMD_W-1:0] noise;
    if (rst_ni) begin
      if (cmd_taken) begin
        cmd_taken = 1'b0;
        cmd_live  = 1'b0;
      end
      if (!cmd_live) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_backlog_q.size() > 0) begin
          cur_cmd  = cmd_backlog_q.pop_front();
          cmd_live = 1'b1;
          if (burst_left == 0) burst_left = $urandom_range(1, 10);
          burst_left--;
          // mostly short gaps, now and then a much longer one that can outlast a whole waveform
          if (burst_left == 0)
            gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(0, 6);
        end
      end
      // the command stays put while full is high, junk otherwise
      noise = CMD_W'($urandom);
      push  <= cmd_live;
      cmd_i <= cmd_live ? cur_cmd : noise;
    end
  end

  // ---------------------------------------------------------------------------
  // pin word receiver: stall modes that change every so often
  // ---------------------------------------------------------------------------

  int          rx_mode    = 0;
  int          rx_left    = 0;
  int          rx_phase   = 0;
  logic [15:0] rx_pat     = '1;
  logic        tail_drain = 1'b0;  // pop without stalls once stimulus is done

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_left == 0) begin
        rx_mode   = $urandom_range(0, 3);
        rx_left   = (rx_mode == 3) ? $urandom_range(10, 90) : $urandom_range(20, 300);
        rx_pat    = 16'($urandom);
        rx_pat[0] = 1'b1;
      end
      rx_left--;
      rx_phase = (rx_phase + 1) % 16;
      if (tail_drain) begin
        pop <= 1'b1;
      end else begin
        case (rx_mode)
          0:       pop <= 1'b1;                          // no stalls
          1:       pop <= rx_pat[rx_phase[3:0]];         // repeating pattern
          2:       pop <= ($urandom_range(0, 3) != 0);   // sparse random stalls
          default: pop <= 1'b0;                          // one long stall
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: both handshakes sampled at the rising edge
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : watch_ports
    ssd_pkg::pin_t exp_ev;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (pin_events_q.size() == 0) begin
          $display("%0t: pin word with none expected, expected none actual %b",
                   $time, res_o);
          errors++;
        end else begin
          exp_ev = pin_events_q.pop_front();
          compare_level("disp_reset_n", exp_ev.disp_reset_n, res_o.disp_reset_n);
          compare_level("serial_data", exp_ev.serial_data, res_o.serial_data);
          compare_level("serial_clock", exp_ev.serial_clock, res_o.serial_clock);
          compare_level("disp_latch", exp_ev.disp_latch, res_o.disp_latch);
          compare_level("matrix_col_clock", exp_ev.matrix_col_clock,
                        res_o.matrix_col_clock);
          compare_level("matrix_reset_n", exp_ev.matrix_reset_n, res_o.matrix_reset_n);
          compare_level("matrix_latch", exp_ev.matrix_latch, res_o.matrix_latch);
          compare_level("last", exp_ev.last, res_o.last);
        end
      end
      if (push && !full) begin
        predict_waveform(cmd_i);
        cmd_taken = 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------

  initial begin
    ssd_pkg::cmd_t c;
    int            valid_cnt;
    int            r;

    // directed part
    cmd_backlog_q.push_back('{ssd_pkg::ACT_REFRESH, 16'h0000, 1'b0});  // cleared word
    cmd_backlog_q.push_back('{ssd_pkg::ACT_NUMBER,  16'd0,     1'b0});
    cmd_backlog_q.push_back('{ssd_pkg::ACT_NUMBER,  16'd99,    1'b1});
    cmd_backlog_q.push_back('{ssd_pkg::ACT_NUMBER,  16'd65535, 1'b0});  // largest number
    cmd_backlog_q.push_back('{ssd_pkg::ACT_NUMBER,  16'd12340, 1'b1});
    cmd_backlog_q.push_back('{ssd_pkg::ACT_NUMBER,  16'd10,    1'b0});
    cmd_backlog_q.push_back('{ssd_pkg::ACT_DIGIT,   16'd7,     1'b0});
    cmd_backlog_q.push_back('{ssd_pkg::ACT_DIGIT,   16'd255,   1'b1});  // digit taken mod ten
    cmd_backlog_q.push_back('{ssd_pkg::ACT_DIGIT,   16'hFF09,  1'b0});  // high bits ignored
    cmd_backlog_q.push_back('{ssd_pkg::ACT_DIGIT,   16'h0010,  1'b1});
    cmd_backlog_q.push_back('{ssd_pkg::ACT_RAW,     16'hFFFF,  1'b0});
    cmd_backlog_q.push_back('{ssd_pkg::ACT_RAW,     16'hAA00,  1'b1});
    cmd_backlog_q.push_back('{ssd_pkg::ACT_RAW,     16'h5A81,  1'b1});
    cmd_backlog_q.push_back('{ssd_pkg::ACT_REFRESH, 16'hFFFF,  1'b1});
    cmd_backlog_q.push_back('{ssd_pkg::ACT_MATRIX,  16'hFFFF,  1'b1});
    cmd_backlog_q.push_back('{ssd_pkg::ACT_MATRIX,  16'h0000,  1'b0});
    cmd_backlog_q.push_back('{ssd_pkg::ACT_MATRIX,  16'h8001,  1'b0});
    cmd_backlog_q.push_back('{ssd_pkg::ACT_MATRIX,  16'h5AA5,  1'b1});
    // spare actions, nothing comes out and the word stays as it is
    cmd_backlog_q.push_back('{ACT_SPARE_5,          16'hFFFF, 1'b1});
    cmd_backlog_q.push_back('{ACT_SPARE_6,          16'h1234, 1'b0});
    cmd_backlog_q.push_back('{ACT_SPARE_7,          16'h0000, 1'b1});
    cmd_backlog_q.push_back('{ssd_pkg::ACT_REFRESH, 16'h0000, 1'b0});

    // random part, spare actions sprinkled in but not counted
    valid_cnt = 0;
    while (valid_cnt < RANDOM_CMDS) begin
      r       = $urandom_range(0, 19);
      c.value = 16'($urandom);
      c.pos   = 1'($urandom_range(0, 1));
      if (r < 3) begin
        c.action = ssd_pkg::ACT_REFRESH;
      end else if (r < 7) begin
        c.action = ssd_pkg::ACT_NUMBER;
        if ($urandom_range(0, 1)) c.value = 16'($urandom_range(0, 99));
      end else if (r < 11) begin
        c.action = ssd_pkg::ACT_DIGIT;
        if ($urandom_range(0, 1)) c.value = 16'($urandom_range(0, 9));
      end else if (r < 15) begin
        c.action = ssd_pkg::ACT_RAW;
      end else if (r < 19) begin
        c.action = ssd_pkg::ACT_MATRIX;
      end else begin
        c.action = 3'($urandom_range(ACT_SPARE_5, ACT_SPARE_7));
      end
      if (r < 19) valid_cnt++;
      cmd_backlog_q.push_back(c);
    end

    // reset held at the start, then released away from the rising edge
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // every command taken, every pin word out, then look for stragglers
    while (cmd_backlog_q.size() != 0 || cmd_live) @(posedge clk_i);
    while (pin_events_q.size() != 0) @(posedge clk_i);
    tail_drain = 1'b1;
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/ssd_pkg.sv
src/ssd_front.sv
src/ssd_job_fifo.sv
src/ssd_back.sv
src/seven_segment_shift_out_driver_core.sv
tb/tb_seven_segment_shift_out_driver_core.sv
